// ===== src/wplc_pkg.sv =====
// Shared types and constants of the winch pull level controller.
// Used by the channel interfaces, the top level and the port checker.
package wplc_pkg;

  // Default timing figures in milliseconds (one tick event is one millisecond).
  localparam int unsigned HoldoffMs     = 1000;
  localparam int unsigned SendPeriodMs  = 400;
  localparam int unsigned LinkTimeoutMs = 1500;
  localparam int unsigned ErrorPeriodMs = 5000;

  localparam int CntW     = 16;
  localparam int PullW    = 8;
  localparam int KgW      = 7;
  localparam int LvlW     = 4;
  localparam int CmdW     = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;
  localparam int ProdW    = 2 * KgW;

  // floor(x / 100) equals (x * 5243) >> 19 for every x below 2**14.
  localparam int RecipW     = 13;
  localparam int RecipShift = 19;
  localparam logic [RecipW-1:0] Recip100 = RecipW'(5243);

  typedef enum logic [CmdW-1:0] {
    CMD_TICK         = 4'd0,
    CMD_UP           = 4'd1,
    CMD_DOWN         = 4'd2,
    CMD_DOWN_LONG    = 4'd3,
    CMD_DOWN_DOUBLE  = 4'd4,
    CMD_THREE        = 4'd5,
    CMD_THREE_DOUBLE = 4'd6,
    CMD_THREE_LONG   = 4'd7,
    CMD_ACK          = 4'd8,
    CMD_MONITOR      = 4'd9
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HARD_BRAKE   = 3'd0,
    CFG_SOFT_BRAKE   = 3'd1,
    CFG_DEFAULT_PULL = 3'd2,
    CFG_PRE_PCT      = 3'd3,
    CFG_TAKEOFF_PCT  = 3'd4,
    CFG_FULL_PCT     = 3'd5,
    CFG_STRONG_PCT   = 3'd6
  } cfg_idx_e;

  localparam logic signed [LvlW-1:0] LvlHardBrake = -4'sd2;
  localparam logic signed [LvlW-1:0] LvlSoftBrake = -4'sd1;
  localparam logic signed [LvlW-1:0] LvlNeutral   = 4'sd0;
  localparam logic signed [LvlW-1:0] LvlDefault   = 4'sd1;
  localparam logic signed [LvlW-1:0] LvlPrePull   = 4'sd2;
  localparam logic signed [LvlW-1:0] LvlTakeoff   = 4'sd3;
  localparam logic signed [LvlW-1:0] LvlFullPull  = 4'sd4;
  localparam logic signed [LvlW-1:0] LvlStrong    = 4'sd5;

  typedef struct packed {
    logic                    send_packet;
    logic signed [LvlW-1:0]  pull_state;
    logic signed [PullW-1:0] target_pull;
    logic                    servo_on;
    logic                    relay_on;
    logic                    link_lost;
    logic [CntW-1:0]         error_count;
    logic signed [PullW-1:0] active_pull;
    logic [KgW-1:0]          battery_pct;
    logic [KgW-1:0]          motor_temp;
  } res_t;

endpackage

// ===== src/wplc_if.sv =====
// Valid/ready channel interfaces of the winch pull level controller:
// the event channel and the result channel. Depends on wplc_pkg.
interface wplc_evt_if;
  import wplc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         cmd;
  logic signed [PullW-1:0] ack_pull;
  logic                    ack_kind;
  logic [KgW-1:0]          ack_value;
  logic                    set_servo;
  logic                    set_relay;
  logic [KgW-1:0]          set_max_pull;

  modport source (output valid, cmd, ack_pull, ack_kind, ack_value, set_servo, set_relay,
                  set_max_pull, input ready);
  modport sink (input valid, cmd, ack_pull, ack_kind, ack_value, set_servo, set_relay,
                set_max_pull, output ready);
endinterface

interface wplc_res_if;
  import wplc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    send_packet;
  logic signed [LvlW-1:0]  pull_state;
  logic signed [PullW-1:0] target_pull;
  logic                    servo_on;
  logic                    relay_on;
  logic                    link_lost;
  logic [CntW-1:0]         error_count;
  logic signed [PullW-1:0] active_pull;
  logic [KgW-1:0]          battery_pct;
  logic [KgW-1:0]          motor_temp;

  modport source (output valid, send_packet, pull_state, target_pull, servo_on, relay_on,
                  link_lost, error_count, active_pull, battery_pct, motor_temp, input ready);
  modport sink (input valid, send_packet, pull_state, target_pull, servo_on, relay_on,
                link_lost, error_count, active_pull, battery_pct, motor_temp, output ready);
endinterface

// ===== src/winch_pull_level_controller.sv =====
// Winch pull level controller: one result beat for every event beat.
// Depends on wplc_pkg and the channel interfaces in wplc_if.sv.
//
// The block takes one event beat per clock, unless a stalled result beat holds the pipeline,
// and returns one result beat per event, in order. The beat passes three registers: the input
// register, the state update stage, and the target and output register. The state update of
// one event completes in the cycle it leaves the input register, so the next event can
// follow directly. The percentage multiply is registered, and the division by one hundred is
// a constant reciprocal multiply in the last stage. A stalled result beat holds the pipeline,
// and up to three events are buffered. Configuration writes take effect on the next clock and
// must only be issued while no event is in flight.
module winch_pull_level_controller #(
  parameter int unsigned HOLDOFF_MS      = wplc_pkg::HoldoffMs,
  parameter int unsigned SEND_PERIOD_MS  = wplc_pkg::SendPeriodMs,
  parameter int unsigned LINK_TIMEOUT_MS = wplc_pkg::LinkTimeoutMs,
  parameter int unsigned ERROR_PERIOD_MS = wplc_pkg::ErrorPeriodMs
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wplc_evt_if.sink                      evt_i,
  wplc_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [wplc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wplc_pkg::CfgDataW-1:0] cfg_data_i
);
  import wplc_pkg::*;

  localparam logic [CntW-1:0] HoldoffLim = CntW'(HOLDOFF_MS);
  localparam logic [CntW-1:0] SendLim    = CntW'(SEND_PERIOD_MS);
  localparam logic [CntW-1:0] LinkLim    = CntW'(LINK_TIMEOUT_MS);
  localparam logic [CntW-1:0] ErrorLim   = CntW'(ERROR_PERIOD_MS);

  // Configuration registers.
  logic signed [PullW-1:0] hard_brake_q, soft_brake_q;
  logic [KgW-1:0]          default_pull_q, pre_pct_q, takeoff_pct_q, full_pct_q, strong_pct_q;

  // Controller state.
  logic signed [LvlW-1:0]  level_q, level_d;
  logic                    changed_q, changed_d;
  logic [CntW-1:0]         switch_ms_q, switch_ms_d;
  logic [CntW-1:0]         send_ms_q, send_ms_d;
  logic [CntW-1:0]         ack_ms_q, ack_ms_d;
  logic [CntW-1:0]         error_ms_q, error_ms_d;
  logic [CntW-1:0]         error_total_q, error_total_d;
  logic signed [PullW-1:0] rep_pull_q, rep_pull_d;
  logic [KgW-1:0]          rep_battery_q, rep_battery_d;
  logic [KgW-1:0]          rep_temp_q, rep_temp_d;
  logic                    servo_q, servo_d;
  logic                    relay_q, relay_d;
  logic [KgW-1:0]          max_pull_q, max_pull_d;

  // Pipeline registers.
  logic                    s1_valid_q;
  logic [CmdW-1:0]         s1_cmd_q;
  logic signed [PullW-1:0] s1_ack_pull_q;
  logic                    s1_ack_kind_q;
  logic [KgW-1:0]          s1_ack_value_q;
  logic                    s1_servo_q, s1_relay_q;
  logic [KgW-1:0]          s1_max_pull_q;

  logic                    s2_valid_q;
  res_t                    s2_res_q, s2_res_d;
  logic [ProdW-1:0]        s2_prod_q, s2_prod_d;

  logic                    out_valid_q;
  res_t                    out_res_q, out_res_d;

  logic out_go, s2_go, s1_go, s1_fire;
  logic send_now, error_hit;
  logic [KgW-1:0] pct_sel;

  logic [ProdW+RecipW-1:0]  quot_full;
  logic [PullW-1:0]         quot;
  logic signed [PullW-1:0]  scaled, target;

  assign out_go  = !out_valid_q || res_o.ready;
  assign s2_go   = !s2_valid_q || out_go;
  assign s1_go   = !s1_valid_q || s2_go;
  assign s1_fire = s1_valid_q && s2_go;
  assign evt_i.ready = s1_go;

  // Apply one event to the state, then the link error check and the send decision.
  always_comb begin
    level_d       = level_q;
    changed_d     = changed_q;
    switch_ms_d   = switch_ms_q;
    send_ms_d     = send_ms_q;
    ack_ms_d      = ack_ms_q;
    error_ms_d    = error_ms_q;
    error_total_d = error_total_q;
    rep_pull_d    = rep_pull_q;
    rep_battery_d = rep_battery_q;
    rep_temp_d    = rep_temp_q;
    servo_d       = servo_q;
    relay_d       = relay_q;
    max_pull_d    = max_pull_q;

    case (s1_cmd_q)
      CMD_TICK: begin
        switch_ms_d = (switch_ms_q == '1) ? switch_ms_q : switch_ms_q + 1'b1;
        send_ms_d   = (send_ms_q == '1) ? send_ms_q : send_ms_q + 1'b1;
        ack_ms_d    = (ack_ms_q == '1) ? ack_ms_q : ack_ms_q + 1'b1;
        error_ms_d  = (error_ms_q == '1) ? error_ms_q : error_ms_q + 1'b1;
      end
      CMD_UP: begin
        if (switch_ms_q > HoldoffLim && level_q < LvlStrong) begin
          // Neutral is skipped on the way up.
          level_d     = (level_q == LvlSoftBrake) ? LvlDefault : level_q + 4'sd1;
          switch_ms_d = '0;
          changed_d   = 1'b1;
        end
      end
      CMD_DOWN: begin
        if (level_q > LvlDefault) begin
          level_d     = LvlDefault;
          switch_ms_d = '0;
          changed_d   = 1'b1;
        end else if (level_q > LvlHardBrake && level_q < LvlDefault) begin
          level_d     = level_q - 4'sd1;
          switch_ms_d = '0;
          changed_d   = 1'b1;
        end
      end
      CMD_DOWN_LONG: begin
        level_d     = LvlSoftBrake;
        switch_ms_d = '0;
        changed_d   = 1'b1;
      end
      CMD_DOWN_DOUBLE: begin
        if (level_q <= LvlSoftBrake) begin
          level_d     = LvlNeutral;
          switch_ms_d = '0;
          changed_d   = 1'b1;
        end
      end
      CMD_THREE: begin
        relay_d     = !relay_q;
        switch_ms_d = '0;
        changed_d   = 1'b1;
      end
      CMD_THREE_DOUBLE: begin
        servo_d     = 1'b0;
        switch_ms_d = '0;
        changed_d   = 1'b1;
      end
      CMD_THREE_LONG: begin
        servo_d = 1'b1;
      end
      CMD_ACK: begin
        rep_pull_d = s1_ack_pull_q;
        if (s1_ack_kind_q) begin
          rep_battery_d = s1_ack_value_q;
        end else begin
          rep_temp_d = s1_ack_value_q;
        end
        ack_ms_d = '0;
      end
      CMD_MONITOR: begin
        servo_d    = s1_servo_q;
        relay_d    = s1_relay_q;
        max_pull_d = s1_max_pull_q;
      end
      default: begin
      end
    endcase

    error_hit = (ack_ms_d > LinkLim) && (error_ms_d > ErrorLim);
    if (error_hit) begin
      error_ms_d    = '0;
      error_total_d = (error_total_d == '1) ? error_total_d : error_total_d + 1'b1;
    end

    send_now = (send_ms_d > SendLim) || changed_d;
    if (send_now) begin
      changed_d = 1'b0;
      send_ms_d = '0;
    end
  end

  // Percentage of the maximum pull for the pulling levels; other levels ignore the product.
  always_comb begin
    case (level_d)
      LvlPrePull:  pct_sel = pre_pct_q;
      LvlTakeoff:  pct_sel = takeoff_pct_q;
      LvlFullPull: pct_sel = full_pct_q;
      LvlStrong:   pct_sel = strong_pct_q;
      default:     pct_sel = '0;
    endcase
    s2_prod_d = {{KgW{1'b0}}, max_pull_d} * {{KgW{1'b0}}, pct_sel};
  end

  always_comb begin
    s2_res_d             = '0;
    s2_res_d.send_packet = send_now;
    s2_res_d.pull_state  = level_d;
    s2_res_d.servo_on    = servo_d;
    s2_res_d.relay_on    = relay_d;
    s2_res_d.link_lost   = ack_ms_d > LinkLim;
    s2_res_d.error_count = error_total_d;
    s2_res_d.active_pull = rep_pull_d;
    s2_res_d.battery_pct = rep_battery_d;
    s2_res_d.motor_temp  = rep_temp_d;
  end

  // Divide the product by one hundred, clamp to the positive range and pick the target per level.
  always_comb begin
    quot_full = {{RecipW{1'b0}}, s2_prod_q} * {{ProdW{1'b0}}, Recip100};
    quot      = quot_full[RecipShift +: PullW];
    scaled    = (quot > PullW'(127)) ? 8'sd127 : signed'(quot);
    case (s2_res_q.pull_state)
      LvlHardBrake: target = hard_brake_q;
      LvlSoftBrake: target = soft_brake_q;
      LvlNeutral:   target = '0;
      LvlDefault:   target = signed'({1'b0, default_pull_q});
      LvlPrePull:   target = scaled;
      LvlTakeoff:   target = scaled;
      LvlFullPull:  target = scaled;
      LvlStrong:    target = scaled;
      default:      target = soft_brake_q;
    endcase
    out_res_d             = s2_res_q;
    out_res_d.target_pull = target;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hard_brake_q   <= -8'sd20;
      soft_brake_q   <= -8'sd7;
      default_pull_q <= KgW'(7);
      pre_pct_q      <= KgW'(18);
      takeoff_pct_q  <= KgW'(55);
      full_pct_q     <= KgW'(80);
      strong_pct_q   <= KgW'(100);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HARD_BRAKE:   hard_brake_q   <= signed'(cfg_data_i);
        CFG_SOFT_BRAKE:   soft_brake_q   <= signed'(cfg_data_i);
        CFG_DEFAULT_PULL: default_pull_q <= cfg_data_i[KgW-1:0];
        CFG_PRE_PCT:      pre_pct_q      <= cfg_data_i[KgW-1:0];
        CFG_TAKEOFF_PCT:  takeoff_pct_q  <= cfg_data_i[KgW-1:0];
        CFG_FULL_PCT:     full_pct_q     <= cfg_data_i[KgW-1:0];
        CFG_STRONG_PCT:   strong_pct_q   <= cfg_data_i[KgW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q       <= LvlSoftBrake;
      changed_q     <= 1'b0;
      switch_ms_q   <= '0;
      send_ms_q     <= '0;
      ack_ms_q      <= '0;
      error_ms_q    <= '0;
      error_total_q <= '0;
      rep_pull_q    <= '0;
      rep_battery_q <= '0;
      rep_temp_q    <= '0;
      servo_q       <= 1'b0;
      relay_q       <= 1'b1;
      max_pull_q    <= KgW'(85);
    end else if (s1_fire) begin
      level_q       <= level_d;
      changed_q     <= changed_d;
      switch_ms_q   <= switch_ms_d;
      send_ms_q     <= send_ms_d;
      ack_ms_q      <= ack_ms_d;
      error_ms_q    <= error_ms_d;
      error_total_q <= error_total_d;
      rep_pull_q    <= rep_pull_d;
      rep_battery_q <= rep_battery_d;
      rep_temp_q    <= rep_temp_d;
      servo_q       <= servo_d;
      relay_q       <= relay_d;
      max_pull_q    <= max_pull_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_go) begin
        s1_valid_q <= evt_i.valid;
      end
      if (s2_go) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_go) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && evt_i.valid) begin
      s1_cmd_q       <= evt_i.cmd;
      s1_ack_pull_q  <= evt_i.ack_pull;
      s1_ack_kind_q  <= evt_i.ack_kind;
      s1_ack_value_q <= evt_i.ack_value;
      s1_servo_q     <= evt_i.set_servo;
      s1_relay_q     <= evt_i.set_relay;
      s1_max_pull_q  <= evt_i.set_max_pull;
    end
    if (s1_fire) begin
      s2_res_q  <= s2_res_d;
      s2_prod_q <= s2_prod_d;
    end
    if (out_go && s2_valid_q) begin
      out_res_q <= out_res_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.send_packet = out_res_q.send_packet;
  assign res_o.pull_state  = out_res_q.pull_state;
  assign res_o.target_pull = out_res_q.target_pull;
  assign res_o.servo_on    = out_res_q.servo_on;
  assign res_o.relay_on    = out_res_q.relay_on;
  assign res_o.link_lost   = out_res_q.link_lost;
  assign res_o.error_count = out_res_q.error_count;
  assign res_o.active_pull = out_res_q.active_pull;
  assign res_o.battery_pct = out_res_q.battery_pct;
  assign res_o.motor_temp  = out_res_q.motor_temp;

endmodule

// ===== src/wplc_checker.sv =====
// Port-level checks of the winch pull level controller and the bind that attaches them.
// Depends on wplc_pkg and on the top level's result channel.
module wplc_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   res_valid_i,
  input logic                                   res_ready_i,
  input logic                                   send_packet_i,
  input logic signed [wplc_pkg::LvlW-1:0]       pull_state_i,
  input logic signed [wplc_pkg::PullW-1:0]      target_pull_i,
  input logic [wplc_pkg::CntW-1:0]              error_count_i
);
  import wplc_pkg::*;

  // A stalled result beat keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(send_packet_i)
      && $stable(pull_state_i) && $stable(target_pull_i) && $stable(error_count_i))
    else $error("stalled result beat changed");

  // The pipeline is empty right after reset.
  assert property (@(posedge clk_i) !rst_ni |=> !res_valid_i)
    else $error("result beat shown right after reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> pull_state_i >= LvlHardBrake && pull_state_i <= LvlStrong)
    else $error("pull level out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && pull_state_i == LvlNeutral |-> target_pull_i == '0)
    else $error("neutral level with nonzero target");

  // Pulling levels never ask for a braking (negative) target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && pull_state_i >= LvlDefault |-> !target_pull_i[PullW-1])
    else $error("pulling level with negative target");

endmodule

bind winch_pull_level_controller wplc_checker u_wplc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .send_packet_i (res_o.send_packet),
  .pull_state_i  (res_o.pull_state),
  .target_pull_i (res_o.target_pull),
  .error_count_i (res_o.error_count)
);
